### sv/lcdf_pkg.sv
// ----------------------------------------------------------------------------
// lcdf_pkg
// Shared types and constants for the LCD readout formatter.
// ----------------------------------------------------------------------------
package lcdf_pkg;

  localparam int unsigned ValW   = 16;
  localparam int unsigned AddrW  = 7;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned RunLen = 33;
  localparam int unsigned StepW  = 6;
  localparam int unsigned MultW  = 17;

  localparam logic [StepW-1:0] LastStep = StepW'(RunLen - 1);

  localparam logic [ByteW-1:0] CmdHome    = 8'h02;
  localparam logic [ByteW-1:0] CmdDdram   = 8'h80;
  localparam logic [ByteW-1:0] AsciiZero  = 8'h30;
  localparam logic [ByteW-1:0] AsciiSpace = 8'h20;
  localparam logic [ByteW-1:0] AsciiComma = 8'h2C;
  localparam logic [ByteW-1:0] AsciiV     = 8'h56;
  localparam logic [ByteW-1:0] AsciiA     = 8'h41;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_ADDR_SET_V,
    REG_ADDR_MEAS_V,
    REG_ADDR_SET_I,
    REG_ADDR_MEAS_I
  } lcdf_reg_e;

  // Write slot inside one field of the run
  typedef enum logic [2:0] {
    SLOT_ADDR,
    SLOT_TEN_THOU,
    SLOT_THOU,
    SLOT_COMMA,
    SLOT_HUND,
    SLOT_TENS,
    SLOT_ONES,
    SLOT_UNIT
  } lcdf_slot_e;

  // Decimal place being extracted
  typedef enum logic [2:0] {
    PLACE_1E4,
    PLACE_1E3,
    PLACE_1E2,
    PLACE_1E1,
    PLACE_1E0
  } lcdf_place_e;

  typedef struct packed {
    logic [AddrW-1:0] set_v;
    logic [AddrW-1:0] meas_v;
    logic [AddrW-1:0] set_i;
    logic [AddrW-1:0] meas_i;
  } lcdf_cfg_t;

  typedef struct packed {
    logic             reg_select;
    logic [ByteW-1:0] bus_byte;
    logic             last_write;
  } lcdf_wr_t;

  // k times the weight of a decimal place; exact for k up to 13, wraps above that at 1e4
  function automatic logic [MultW-1:0] lcdf_multiple(lcdf_place_e place, logic [3:0] k);
    logic [MultW-1:0] pow;
    case (place)
      PLACE_1E4: pow = 17'd10000;
      PLACE_1E3: pow = 17'd1000;
      PLACE_1E2: pow = 17'd100;
      PLACE_1E1: pow = 17'd10;
      PLACE_1E0: pow = 17'd1;
      default:   pow = 17'd1;
    endcase
    return MultW'(k) * pow;
  endfunction

endpackage

### sv/lcdf_cfg.sv
// ----------------------------------------------------------------------------
// lcdf_cfg
// DDRAM address registers for the four readout fields.
// ----------------------------------------------------------------------------
module lcdf_cfg (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [lcdf_pkg::AddrW-1:0]   cfg_wdata_i,
  output lcdf_pkg::lcdf_cfg_t          cfg_o
);
  import lcdf_pkg::*;

  lcdf_cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.set_v  <= 7'd0;
      cfg_q.meas_v <= 7'd64;
      cfg_q.set_i  <= 7'd8;
      cfg_q.meas_i <= 7'd72;
    end else if (cfg_we_i) begin
      case (lcdf_reg_e'(cfg_index_i))
        REG_ADDR_SET_V:  cfg_q.set_v  <= cfg_wdata_i;
        REG_ADDR_MEAS_V: cfg_q.meas_v <= cfg_wdata_i;
        REG_ADDR_SET_I:  cfg_q.set_i  <= cfg_wdata_i;
        REG_ADDR_MEAS_I: cfg_q.meas_i <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/lcdf_digit.sv
// ----------------------------------------------------------------------------
// lcdf_digit
// One decimal digit step: digit of the remainder at a given place, and the
// remainder left for the lower places.
// ----------------------------------------------------------------------------
module lcdf_digit (
  input  lcdf_pkg::lcdf_place_e        place_i,
  input  logic [lcdf_pkg::ValW-1:0]    rem_i,
  output logic [3:0]                   digit_o,
  output logic [lcdf_pkg::ValW-1:0]    rem_o
);
  import lcdf_pkg::*;

  logic [MultW-1:0] rem_ext;
  logic [MultW-1:0] diff;

  // parallel compare against 1..9 times the place weight
  always_comb begin
    rem_ext = {1'b0, rem_i};
    digit_o = '0;
    for (int k = 1; k <= 9; k++) begin
      if (rem_ext >= lcdf_multiple(place_i, 4'(k))) begin
        digit_o = 4'(k);
      end
    end
    diff  = rem_ext - lcdf_multiple(place_i, digit_o);
    rem_o = diff[ValW-1:0];
  end

endmodule

### sv/lcdf_seq.sv
// ----------------------------------------------------------------------------
// lcdf_seq
// Holds the current request and steps through its 33 bus writes,
// extracting one decimal digit per digit write.
// ----------------------------------------------------------------------------
module lcdf_seq (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lcdf_pkg::lcdf_cfg_t          cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcdf_pkg::ValW-1:0]    set_voltage_i,
  input  logic [lcdf_pkg::ValW-1:0]    measured_voltage_i,
  input  logic [lcdf_pkg::ValW-1:0]    set_current_i,
  input  logic [lcdf_pkg::ValW-1:0]    measured_current_i,
  input  logic                         wr_ready_i,
  output logic                         wr_valid_o,
  output lcdf_pkg::lcdf_wr_t           wr_o
);
  import lcdf_pkg::*;

  logic             item_valid_q;
  logic [StepW-1:0] step_q;
  logic [ValW-1:0]  val_q [4];
  logic [ValW-1:0]  rem_q;

  logic [StepW-1:0] step_m1;
  logic [1:0]       field;
  lcdf_slot_e       slot;
  logic             is_home;
  logic             is_last;
  logic             advance;
  logic             accept;
  logic             digit_slot;
  lcdf_place_e      place;
  logic [3:0]       digit;
  logic [ValW-1:0]  rem_next;
  logic [AddrW-1:0] field_addr;
  logic [ByteW-1:0] digit_char;

  always_comb begin
    step_m1 = step_q - 6'd1;
    field   = step_m1[4:3];
    slot    = lcdf_slot_e'(step_m1[2:0]);
    is_home = (step_q == '0);
    is_last = (step_q == LastStep);
  end

  assign advance    = item_valid_q & wr_ready_i;
  assign in_stall_o = item_valid_q & ~(advance & is_last);
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    digit_slot = ~is_home;
    place      = PLACE_1E0;
    case (slot)
      SLOT_TEN_THOU: place = PLACE_1E4;
      SLOT_THOU:     place = PLACE_1E3;
      SLOT_HUND:     place = PLACE_1E2;
      SLOT_TENS:     place = PLACE_1E1;
      SLOT_ONES:     place = PLACE_1E0;
      default:       digit_slot = 1'b0;
    endcase
  end

  lcdf_digit u_digit (
    .place_i (place),
    .rem_i   (rem_q),
    .digit_o (digit),
    .rem_o   (rem_next)
  );

  always_comb begin
    case (field)
      2'd0:    field_addr = cfg_i.set_v;
      2'd1:    field_addr = cfg_i.meas_v;
      2'd2:    field_addr = cfg_i.set_i;
      default: field_addr = cfg_i.meas_i;
    endcase
  end

  assign digit_char = AsciiZero + ByteW'(digit);

  always_comb begin
    wr_o.reg_select = 1'b1;
    wr_o.last_write = is_last;
    wr_o.bus_byte   = digit_char;
    if (is_home) begin
      wr_o.reg_select = 1'b0;
      wr_o.bus_byte   = CmdHome;
    end else begin
      case (slot)
        SLOT_ADDR: begin
          wr_o.reg_select = 1'b0;
          wr_o.bus_byte   = CmdDdram | ByteW'(field_addr);
        end
        SLOT_TEN_THOU: wr_o.bus_byte = (digit == 4'd0) ? AsciiSpace : digit_char;
        SLOT_COMMA:    wr_o.bus_byte = AsciiComma;
        SLOT_UNIT:     wr_o.bus_byte = field[1] ? AsciiA : AsciiV;
        default:       wr_o.bus_byte = digit_char;
      endcase
    end
  end

  assign wr_valid_o = item_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      step_q       <= '0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
      step_q       <= '0;
    end else if (advance) begin
      if (is_last) begin
        item_valid_q <= 1'b0;
      end else begin
        step_q <= step_q + 6'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      val_q[0] <= set_voltage_i;
      val_q[1] <= measured_voltage_i;
      val_q[2] <= set_current_i;
      val_q[3] <= measured_current_i;
    end
    // remainder is loaded on the address write, consumed on digit writes
    if (advance && !is_home) begin
      if (slot == SLOT_ADDR) begin
        rem_q <= val_q[field];
      end else if (digit_slot) begin
        rem_q <= rem_next;
      end
    end
  end

`ifndef ASSERT_OFF
  a_step_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid_q |-> step_q <= LastStep)
    else $error("step counter past end of run");

  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && digit_slot) |-> ({1'b0, rem_q} < lcdf_multiple(place, 4'd10)))
    else $error("remainder too large for digit place");

  a_digit_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid_q && digit_slot) |-> digit <= 4'd9)
    else $error("digit out of decimal range");

  a_new_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (item_valid_q && is_home))
    else $error("new request did not start at return-home");

  a_run_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && is_last && !accept) |=> !item_valid_q)
    else $error("request still held after its last write");
`endif

endmodule

### sv/lcdf_out_reg.sv
// ----------------------------------------------------------------------------
// lcdf_out_reg
// Output register for the LCD bus writes.
// ----------------------------------------------------------------------------
module lcdf_out_reg (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_valid_i,
  input  lcdf_pkg::lcdf_wr_t   wr_i,
  output logic                 wr_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output lcdf_pkg::lcdf_wr_t   out_o
);
  import lcdf_pkg::*;

  logic     out_valid_q;
  lcdf_wr_t wr_q;

  assign wr_ready_o = ~out_valid_q | ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_ready_o) begin
      out_valid_q <= wr_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_ready_o && wr_valid_i) begin
      wr_q <= wr_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = wr_q;

endmodule

### sv/lcd_readout_formatter.sv
// ----------------------------------------------------------------------------
// lcd_readout_formatter
// Turns four 16-bit readings into one run of character-LCD bus writes.
// ----------------------------------------------------------------------------
// Each request (set voltage, measured voltage, set current, measured current)
// produces 33 LCD writes: return-home, then per reading a set-DDRAM-address
// command (configured address | 0x80), five decimal digits with the leading
// zero blanked and a comma after the second digit, and the unit letter V or A.
// One write leaves per cycle through the output register while out_stall_i
// is low, and the next request is taken on the same edge that loads the
// run's last write into the output register. Digits are produced one per
// write from a running remainder. last_write_o flags the final write. The
// user must write the address registers only while no run is in flight;
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module lcd_readout_formatter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [1:0]                   cfg_index_i,
  input  logic [lcdf_pkg::AddrW-1:0]   cfg_wdata_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [lcdf_pkg::ValW-1:0]    set_voltage_i,
  input  logic [lcdf_pkg::ValW-1:0]    measured_voltage_i,
  input  logic [lcdf_pkg::ValW-1:0]    set_current_i,
  input  logic [lcdf_pkg::ValW-1:0]    measured_current_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         reg_select_o,
  output logic [lcdf_pkg::ByteW-1:0]   bus_byte_o,
  output logic                         last_write_o
);
  import lcdf_pkg::*;

  lcdf_cfg_t cfg;
  logic      wr_valid;
  logic      wr_ready;
  lcdf_wr_t  wr;
  lcdf_wr_t  out_wr;

  lcdf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  lcdf_seq u_seq (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .set_voltage_i      (set_voltage_i),
    .measured_voltage_i (measured_voltage_i),
    .set_current_i      (set_current_i),
    .measured_current_i (measured_current_i),
    .wr_ready_i         (wr_ready),
    .wr_valid_o         (wr_valid),
    .wr_o               (wr)
  );

  lcdf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_valid_i  (wr_valid),
    .wr_i        (wr),
    .wr_ready_o  (wr_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (out_wr)
  );

  assign reg_select_o = out_wr.reg_select;
  assign bus_byte_o   = out_wr.bus_byte;
  assign last_write_o = out_wr.last_write;

endmodule
